[hdl/polar_angle_degrees_assert.svh]
// assertion macros shared by the polar angle checker
`ifndef POLAR_ANGLE_DEGREES_ASSERT_SVH
`define POLAR_ANGLE_DEGREES_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PAD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PAD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pad_pkg.sv]
// shared constants, angle step table and flag type for the polar angle pipeline
package pad_pkg;

	// default parameter values
	localparam int COORD_WIDTH_DEF     = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int CORDIC_STAGES_DEF   = 16;

	// internal number formats
	localparam int QFRAC        = 24;  // fraction bits of the internal angle
	localparam int CORDIC_WIDTH = 64;  // x and y datapath width
	localparam int PRESHIFT_TOP = 60;  // coordinates are aligned up to this bit
	localparam int Z_WIDTH      = 32;  // signed angle accumulator
	localparam int A_WIDTH      = 34;  // unsigned full-circle angle
	localparam int LAST_STEP    = 31;  // steps beyond this reuse its entry and shift

	// fixed angles in internal format
	localparam logic [A_WIDTH-1:0] DEG90_Q  = A_WIDTH'(90)  << QFRAC;
	localparam logic [A_WIDTH-1:0] DEG180_Q = A_WIDTH'(180) << QFRAC;
	localparam logic [A_WIDTH-1:0] DEG270_Q = A_WIDTH'(270) << QFRAC;
	localparam logic [A_WIDTH-1:0] DEG360_Q = A_WIDTH'(360) << QFRAC;

	// atan(2^-i) in degrees, rounded to QFRAC fraction bits
	localparam logic signed [Z_WIDTH-1:0] STEP_DEG [0:LAST_STEP] = '{
		32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
		32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
		32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
		32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
		32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
		32'sd917,       32'sd458,       32'sd229,       32'sd115,
		32'sd57,        32'sd29,        32'sd14,        32'sd7,
		32'sd4,         32'sd2,         32'sd1,         32'sd0
	};

	// point classification carried alongside the rotation
	typedef struct packed {
		logic is_origin;
		logic on_yaxis;
		logic y_zero;
		logic x_neg;
		logic y_neg;
	} flags_t;

endpackage

[hdl/pad_cordic_cell.sv]
// one vectoring rotation step of the angle pipeline
module pad_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [pad_pkg::CORDIC_WIDTH-1:0]  in_cx,
	input  logic signed [pad_pkg::CORDIC_WIDTH-1:0]  in_cy,
	input  logic signed [pad_pkg::Z_WIDTH-1:0]       in_z,
	input  pad_pkg::flags_t                          in_flags,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [pad_pkg::CORDIC_WIDTH-1:0]  out_cx,
	output logic signed [pad_pkg::CORDIC_WIDTH-1:0]  out_cy,
	output logic signed [pad_pkg::Z_WIDTH-1:0]       out_z,
	output pad_pkg::flags_t                          out_flags
);

	localparam int K = (IDX < pad_pkg::LAST_STEP) ? IDX : pad_pkg::LAST_STEP;
	localparam logic signed [pad_pkg::Z_WIDTH-1:0] STEP = pad_pkg::STEP_DEG[K];

	logic signed [pad_pkg::CORDIC_WIDTH-1:0] dx, dy, cx_d, cy_d;
	logic signed [pad_pkg::Z_WIDTH-1:0]      z_d;
	logic                                    valid_q;
	logic signed [pad_pkg::CORDIC_WIDTH-1:0] cx_q, cy_q;
	logic signed [pad_pkg::Z_WIDTH-1:0]      z_q;
	pad_pkg::flags_t                         flags_q;

	// rotate toward the x axis, direction from the sign of y
	always_comb begin
		dx = in_cx >>> K;
		dy = in_cy >>> K;
		if (in_cy > 0) begin
			cx_d = in_cx + dy;
			cy_d = in_cy - dx;
			z_d  = in_z + STEP;
		end else begin
			cx_d = in_cx - dy;
			cy_d = in_cy + dx;
			z_d  = in_z - STEP;
		end
	end

	// cell is free when empty or when its content moves on
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cx_q    <= cx_d;
			cy_q    <= cy_d;
			z_q     <= z_d;
			flags_q <= in_flags;
		end
	end

	assign out_valid = valid_q;
	assign out_cx    = cx_q;
	assign out_cy    = cy_q;
	assign out_z     = z_q;
	assign out_flags = flags_q;

endmodule

[hdl/pad_prep.sv]
// input stage: magnitudes, alignment and point classification
module pad_prep #(
	parameter int COORD_WIDTH = pad_pkg::COORD_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [COORD_WIDTH-1:0]                   x_coord,
	input  logic [COORD_WIDTH-1:0]                   y_coord,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [pad_pkg::CORDIC_WIDTH-1:0]  out_cx,
	output logic signed [pad_pkg::CORDIC_WIDTH-1:0]  out_cy,
	output pad_pkg::flags_t                          out_flags
);

	localparam int PRESHIFT = pad_pkg::PRESHIFT_TOP - COORD_WIDTH;

	logic                                    x_neg, y_neg;
	logic [COORD_WIDTH-1:0]                  ax, ay;
	pad_pkg::flags_t                         flags_d;
	logic                                    valid_q;
	logic signed [pad_pkg::CORDIC_WIDTH-1:0] cx_q, cy_q;
	pad_pkg::flags_t                         flags_q;

	// magnitudes; the most negative value maps to its unsigned magnitude
	always_comb begin
		x_neg             = x_coord[COORD_WIDTH-1];
		y_neg             = y_coord[COORD_WIDTH-1];
		ax                = x_neg ? (~x_coord + 1'b1) : x_coord;
		ay                = y_neg ? (~y_coord + 1'b1) : y_coord;
		flags_d.is_origin = (ax == '0) && (ay == '0);
		flags_d.on_yaxis  = (ax == '0);
		flags_d.y_zero    = (ay == '0);
		flags_d.x_neg     = x_neg;
		flags_d.y_neg     = y_neg;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// align magnitudes to the top of the rotation datapath
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cx_q    <= $signed(pad_pkg::CORDIC_WIDTH'(ax) << PRESHIFT);
			cy_q    <= $signed(pad_pkg::CORDIC_WIDTH'(ay) << PRESHIFT);
			flags_q <= flags_d;
		end
	end

	assign out_valid = valid_q;
	assign out_cx    = cx_q;
	assign out_cy    = cy_q;
	assign out_flags = flags_q;

endmodule

[hdl/pad_post.sv]
// output stages: clamp, quadrant placement, rounding and wrap
module pad_post #(
	parameter int ANGLE_FRAC_BITS = pad_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int ANGLE_W         = 9 + ANGLE_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [pad_pkg::Z_WIDTH-1:0] in_z,
	input  pad_pkg::flags_t                    in_flags,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ANGLE_W-1:0]                 angle,
	output logic                               is_origin
);

	localparam int DROP = pad_pkg::QFRAC - ANGLE_FRAC_BITS;
	localparam logic [pad_pkg::A_WIDTH-1:0] HALF = pad_pkg::A_WIDTH'(1) << (DROP - 1);
	localparam logic [pad_pkg::A_WIDTH-1:0] FULL =
		pad_pkg::A_WIDTH'(360) << ANGLE_FRAC_BITS;

	logic [pad_pkg::A_WIDTH-1:0] t, a_d, r_d;
	logic                        ready_s1, ready_s2;
	logic                        valid_s1, valid_s2;
	logic [pad_pkg::A_WIDTH-1:0] a_s1;
	logic                        origin_s1, origin_s2;
	logic [ANGLE_W-1:0]          angle_s2;

	// clamp to [0, 90] degrees and place in the quadrant
	always_comb begin
		if (in_z < 0) begin
			t = '0;
		end else if (pad_pkg::A_WIDTH'(in_z) > pad_pkg::DEG90_Q) begin
			t = pad_pkg::DEG90_Q;
		end else begin
			t = pad_pkg::A_WIDTH'(in_z);
		end
		if (in_flags.y_zero) begin
			t = '0;
		end
		if (in_flags.is_origin) begin
			a_d = '0;
		end else if (in_flags.on_yaxis) begin
			a_d = in_flags.y_neg ? pad_pkg::DEG270_Q : pad_pkg::DEG90_Q;
		end else if (!in_flags.x_neg) begin
			a_d = in_flags.y_neg ? (pad_pkg::DEG360_Q - t) : t;
		end else if (!in_flags.y_zero && !in_flags.y_neg) begin
			a_d = pad_pkg::DEG180_Q - t;
		end else begin
			a_d = pad_pkg::DEG180_Q + t;
		end
	end

	// round half up to the output fraction, wrap a full circle to zero
	always_comb begin
		r_d = (a_s1 + HALF) >> DROP;
		if (r_d >= FULL) begin
			r_d = r_d - FULL;
		end
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			a_s1      <= a_d;
			origin_s1 <= in_flags.is_origin;
		end
		if (ready_s2 && valid_s1) begin
			angle_s2  <= r_d[ANGLE_W-1:0];
			origin_s2 <= origin_s1;
		end
	end

	assign out_valid = valid_s2;
	assign angle     = angle_s2;
	assign is_origin = origin_s2;

endmodule

[hdl/polar_angle_degrees.sv]
// polar angle of a signed point in degrees by a chain of vectoring rotation cells
// throughput: one transaction per cycle while the output is not stalled, set by one rotation step per cell in the chain
// each stage holds while the next one is full and stalled, so stalls back up stage by stage
// reset clears only the stage valid bits; no memory and no clearing pass
module polar_angle_degrees #(
	parameter int COORD_WIDTH     = pad_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = pad_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = pad_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_W         = 9 + ANGLE_FRAC_BITS,
	parameter int S_TDATA_W       = ((2 * COORD_WIDTH + 7) / 8) * 8,
	parameter int M_TDATA_W       = ((ANGLE_W + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // x_coord, y_coord, zero fill
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // angle, zero fill
	output logic [0:0]           m_tuser    // is_origin
);

	logic                                    valid_c [0:CORDIC_STAGES];
	logic                                    ready_c [0:CORDIC_STAGES];
	logic signed [pad_pkg::CORDIC_WIDTH-1:0] cx_c    [0:CORDIC_STAGES];
	logic signed [pad_pkg::CORDIC_WIDTH-1:0] cy_c    [0:CORDIC_STAGES];
	logic signed [pad_pkg::Z_WIDTH-1:0]      z_c     [0:CORDIC_STAGES];
	pad_pkg::flags_t                         flags_c [0:CORDIC_STAGES];
	logic [ANGLE_W-1:0]                      angle;
	logic                                    is_origin;

	// classification and alignment
	pad_prep #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.x_coord  (s_tdata[COORD_WIDTH-1:0]),
		.y_coord  (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.out_valid(valid_c[0]),
		.out_ready(ready_c[0]),
		.out_cx   (cx_c[0]),
		.out_cy   (cy_c[0]),
		.out_flags(flags_c[0])
	);

	assign z_c[0] = '0;

	// rotation chain, one step per cell
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		pad_cordic_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_ready (ready_c[i]),
			.in_cx    (cx_c[i]),
			.in_cy    (cy_c[i]),
			.in_z     (z_c[i]),
			.in_flags (flags_c[i]),
			.out_valid(valid_c[i+1]),
			.out_ready(ready_c[i+1]),
			.out_cx   (cx_c[i+1]),
			.out_cy   (cy_c[i+1]),
			.out_z    (z_c[i+1]),
			.out_flags(flags_c[i+1])
		);
	end

	// quadrant placement and rounding
	pad_post #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.ANGLE_W        (ANGLE_W)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[CORDIC_STAGES]),
		.in_ready (ready_c[CORDIC_STAGES]),
		.in_z     (z_c[CORDIC_STAGES]),
		.in_flags (flags_c[CORDIC_STAGES]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.angle    (angle),
		.is_origin(is_origin)
	);

	assign m_tdata = M_TDATA_W'(angle);
	assign m_tuser = is_origin;

endmodule

[hdl/pad_checker.sv]
// port-level checks of the polar angle block, bound to the top level
`include "polar_angle_degrees_assert.svh"

module pad_checker #(
	parameter int ANGLE_FRAC_BITS = pad_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int ANGLE_W         = 9 + ANGLE_FRAC_BITS,
	parameter int M_TDATA_W       = ((ANGLE_W + 7) / 8) * 8
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [0:0]           m_tuser
);

	localparam logic [ANGLE_W-1:0] FULL = ANGLE_W'(360) << ANGLE_FRAC_BITS;

	// a stalled result transaction holds its payload
	`PAD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// the origin reports a zero angle
	`PAD_ASSERT_NOW(a_origin_zero, m_tvalid && m_tuser[0], m_tdata == '0, "origin with nonzero angle")

	// angle stays below a full circle
	`PAD_ASSERT_NOW(a_angle_range, m_tvalid, m_tdata[ANGLE_W-1:0] < FULL, "angle out of range")

	// input side only blocks when the whole chain is full behind a stalled output
	`PAD_ASSERT_NOW(a_backpressure, !s_tready, m_tvalid && !m_tready, "input blocked without output stall")

endmodule

bind polar_angle_degrees pad_checker #(
	.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_pad_checker (.*);
